// ===== hdl/sbhs_pkg.sv =====
package sbhs_pkg;

    localparam int FRAME_WIDTH  = 480;
    localparam int FRAME_HEIGHT = 360;
    localparam int PIX_COUNT    = FRAME_WIDTH * FRAME_HEIGHT;
    localparam int ADDR_W       = $clog2(PIX_COUNT);

    localparam int CFG_TRAIL = 0;
    localparam int CFG_GAIN  = 1;

    typedef logic [8:0]        path_rom_t [512];
    typedef logic signed [4:0] wob_rom_t  [1024];

    localparam real AngleDen  = 640000000.0;
    localparam real AngleStep = 7853940.0;

    function automatic path_rom_t build_x_path();
        path_rom_t rom;
        real a;
        for (int i = 0; i < 512; i++) begin
            a = (2.0 * i * AngleStep) / AngleDen;
            rom[i] = 9'($rtoi($floor(232.0 + 165.0 * $sin(a))));
        end
        return rom;
    endfunction

    function automatic path_rom_t build_y_path();
        path_rom_t rom;
        real a;
        for (int i = 0; i < 512; i++) begin
            a = (i * AngleStep) / AngleDen;
            rom[i] = 9'($rtoi($floor(172.0 + 90.0 * $sin(a))));
        end
        return rom;
    endfunction

    function automatic wob_rom_t build_wobble();
        wob_rom_t rom;
        real b;
        for (int i = 0; i < 1024; i++) begin
            b = (i * (AngleStep / 2.0)) / AngleDen;
            rom[i] = 5'($rtoi(15.0 * $sin(b)));
        end
        return rom;
    endfunction

    localparam path_rom_t X_PATH = build_x_path();
    localparam path_rom_t Y_PATH = build_y_path();
    localparam wob_rom_t  WOBBLE = build_wobble();

    localparam logic [2:0] STAMP_ROM [256] = '{
        0,0,0,0,0,0,0,1,1,0,0,0,0,0,0,0,
        0,0,0,0,0,1,1,1,1,1,1,0,0,0,0,0,
        0,0,0,1,1,1,2,2,2,2,1,1,1,0,0,0,
        0,0,1,1,2,2,2,3,3,2,2,2,1,1,0,0,
        0,0,1,2,2,3,3,3,3,3,3,2,2,1,0,0,
        0,1,1,2,3,3,3,3,3,3,3,3,2,1,1,0,
        0,1,2,2,3,3,3,4,4,3,3,3,2,2,1,0,
        1,1,2,3,3,3,4,4,4,4,3,3,3,2,1,1,
        1,1,2,3,3,3,4,4,4,4,3,3,3,2,1,1,
        0,1,2,2,3,3,3,4,4,3,3,3,2,2,1,0,
        0,1,1,2,3,3,3,3,3,3,3,3,2,1,1,0,
        0,0,1,2,2,3,3,3,3,3,3,2,2,1,0,0,
        0,0,1,1,2,2,2,3,3,2,2,2,1,1,0,0,
        0,0,0,1,1,1,2,2,2,2,1,1,1,0,0,0,
        0,0,0,0,0,1,1,1,1,1,1,0,0,0,0,0,
        0,0,0,0,0,0,0,1,1,0,0,0,0,0,0,0
    };

    typedef struct packed {
        logic clr_step;
        logic load_in;
        logic arm_eval;
        logic rom_rd;
        logic sel_head;
        logic pos_ld;
        logic tail_clr;
        logic pix_rd;
        logic pix_wr;
        logic tick_inc;
        logic rd_px;
        logic out_ld;
    } cmd_t;

    typedef struct packed {
        logic clr_last;
        logic op;
        logic armed;
        logic cnt_last;
        logic out_free;
    } status_t;

endpackage

// ===== hdl/sbhs_ctrl.sv =====
module sbhs_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  sbhs_pkg::status_t sts,
    output sbhs_pkg::cmd_t   cmd
);
    import sbhs_pkg::*;

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_ARM   = 4'd2;
    localparam logic [3:0] S_TROM  = 4'd3;
    localparam logic [3:0] S_TPOS  = 4'd4;
    localparam logic [3:0] S_TRD   = 4'd5;
    localparam logic [3:0] S_TWR   = 4'd6;
    localparam logic [3:0] S_HROM  = 4'd7;
    localparam logic [3:0] S_HPOS  = 4'd8;
    localparam logic [3:0] S_HRD   = 4'd9;
    localparam logic [3:0] S_HWR   = 4'd10;
    localparam logic [3:0] S_PRD   = 4'd11;
    localparam logic [3:0] S_DONE  = 4'd12;

    logic [3:0] state_reg, state_next;

    assign s_tready = (state_reg == S_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR: begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last) state_next = S_IDLE;
            end
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.load_in = 1'b1;
                    state_next  = S_ARM;
                end
            end
            S_ARM: begin
                if (sts.op) begin
                    state_next = S_PRD;
                end else begin
                    cmd.arm_eval = 1'b1;
                    state_next   = S_TROM;
                end
            end
            S_TROM: begin
                if (sts.armed) begin
                    cmd.rom_rd = 1'b1;
                    state_next = S_TPOS;
                end else begin
                    cmd.tail_clr = 1'b1;
                    state_next   = S_HROM;
                end
            end
            S_TPOS: begin
                cmd.pos_ld = 1'b1;
                state_next = S_TRD;
            end
            S_TRD: begin
                cmd.pix_rd = 1'b1;
                state_next = S_TWR;
            end
            S_TWR: begin
                cmd.pix_wr = 1'b1;
                state_next = sts.cnt_last ? S_HROM : S_TRD;
            end
            S_HROM: begin
                cmd.rom_rd   = 1'b1;
                cmd.sel_head = 1'b1;
                state_next   = S_HPOS;
            end
            S_HPOS: begin
                cmd.pos_ld   = 1'b1;
                cmd.sel_head = 1'b1;
                state_next   = S_HRD;
            end
            S_HRD: begin
                cmd.pix_rd   = 1'b1;
                cmd.sel_head = 1'b1;
                state_next   = S_HWR;
            end
            S_HWR: begin
                cmd.pix_wr   = 1'b1;
                cmd.sel_head = 1'b1;
                if (sts.cnt_last) begin
                    cmd.tick_inc = 1'b1;
                    state_next   = S_DONE;
                end else begin
                    state_next = S_HRD;
                end
            end
            S_PRD: begin
                cmd.rd_px  = 1'b1;
                state_next = S_DONE;
            end
            S_DONE: begin
                if (sts.out_free) begin
                    cmd.out_ld = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_CLEAR;
        endcase
    end

endmodule

// ===== hdl/sbhs_datapath.sv =====
module sbhs_datapath (
    input  logic              aclk,
    input  logic              aresetn,
    input  sbhs_pkg::cmd_t    cmd,
    output sbhs_pkg::status_t sts,
    input  logic              in_op,
    input  logic [8:0]        in_x,
    input  logic [8:0]        in_y,
    input  logic              cfg_we,
    input  logic              cfg_index,
    input  logic [9:0]        cfg_data,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [7:0]        out_pv,
    output logic [8:0]        out_hx,
    output logic [8:0]        out_hy,
    output logic [8:0]        out_tx,
    output logic [8:0]        out_ty,
    output logic              out_tv
);
    import sbhs_pkg::*;

    logic [7:0] mem [PIX_COUNT];

    logic [9:0]  trail_reg, tick_reg;
    logic [7:0]  gain_reg;
    logic        armed_reg;
    logic        op_reg;
    logic [8:0]  px_reg, py_reg;
    logic [ADDR_W-1:0] clr_reg;
    logic [8:0]  xrom_q, yrom_q;
    logic signed [4:0] wob_q;
    logic [8:0]  cx_reg, cy_reg;
    logic [7:0]  cnt_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic        inb_reg;
    logic        add_reg;
    logic [9:0]  amt_reg;
    logic [7:0]  mem_q;
    logic [8:0]  hx_reg, hy_reg, tx_reg, ty_reg;
    logic        tv_reg;
    logic        ovalid_reg;
    logic [7:0]  opv_reg;
    logic [8:0]  ohx_reg, ohy_reg, otx_reg, oty_reg;
    logic        otv_reg;

    logic [9:0]  rom_idx;
    logic [9:0]  st_x, st_y;
    logic [19:0] st_addr, rd_addr;
    logic        st_inb, rd_inb;
    logic [10:0] sum;
    logic [7:0]  newv;
    logic [8:0]  pos_x, pos_y;

    assign rom_idx = cmd.sel_head ? tick_reg : tick_reg - trail_reg;
    assign pos_x   = xrom_q + 9'(wob_q);
    assign pos_y   = yrom_q + 9'(wob_q);

    // stamp pixel: row in the high nibble, column in the low nibble
    assign st_x    = 10'(cx_reg) + 10'(cnt_reg[3:0]);
    assign st_y    = 10'(cy_reg) + 10'(cnt_reg[7:4]);
    assign st_addr = 20'(st_y) * 20'(FRAME_WIDTH) + 20'(st_x);
    assign st_inb  = (st_x < 10'(FRAME_WIDTH)) && (st_y < 10'(FRAME_HEIGHT));
    assign rd_addr = 20'(py_reg) * 20'(FRAME_WIDTH) + 20'(px_reg);
    assign rd_inb  = (10'(px_reg) < 10'(FRAME_WIDTH)) && (10'(py_reg) < 10'(FRAME_HEIGHT));

    always_comb begin
        sum = 11'(mem_q) + 11'(amt_reg);
        if (add_reg) begin
            newv = (sum > 11'd255) ? 8'd255 : sum[7:0];
        end else begin
            newv = (amt_reg > 10'(mem_q)) ? 8'd0 : 8'(10'(mem_q) - amt_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.clr_step) begin
            mem[clr_reg] <= 8'd0;
        end else if (cmd.pix_wr && inb_reg) begin
            mem[addr_reg] <= newv;
        end
        if (cmd.rd_px) begin
            mem_q <= mem[rd_addr[ADDR_W-1:0]];
        end else if (cmd.pix_rd) begin
            mem_q <= mem[st_addr[ADDR_W-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            op_reg <= in_op;
            px_reg <= in_x;
            py_reg <= in_y;
        end
        if (cmd.rom_rd) begin
            xrom_q <= X_PATH[rom_idx[8:0]];
            yrom_q <= Y_PATH[rom_idx[8:0]];
            wob_q  <= WOBBLE[rom_idx];
        end
        if (cmd.pos_ld) begin
            cx_reg <= pos_x;
            cy_reg <= pos_y;
        end
        if (cmd.pix_rd) begin
            addr_reg <= st_addr[ADDR_W-1:0];
            inb_reg  <= st_inb;
            add_reg  <= cmd.sel_head;
            amt_reg  <= 10'(STAMP_ROM[cnt_reg]) * 10'(gain_reg);
        end else if (cmd.rd_px) begin
            inb_reg <= rd_inb;
        end
        if (cmd.out_ld) begin
            opv_reg <= (op_reg && inb_reg) ? mem_q : 8'd0;
            ohx_reg <= hx_reg;
            ohy_reg <= hy_reg;
            otx_reg <= tx_reg;
            oty_reg <= ty_reg;
            otv_reg <= tv_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            trail_reg  <= 10'd500;
            gain_reg   <= 8'd8;
            tick_reg   <= '0;
            armed_reg  <= 1'b0;
            clr_reg    <= '0;
            cnt_reg    <= '0;
            hx_reg     <= '0;
            hy_reg     <= '0;
            tx_reg     <= '0;
            ty_reg     <= '0;
            tv_reg     <= 1'b0;
            ovalid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                if (cfg_index == 1'(CFG_TRAIL)) trail_reg <= cfg_data;
                else gain_reg <= cfg_data[7:0];
            end
            if (cmd.clr_step) clr_reg <= clr_reg + 1'b1;
            if (cmd.arm_eval && (tick_reg >= trail_reg)) armed_reg <= 1'b1;
            if (cmd.tail_clr) begin
                tx_reg <= '0;
                ty_reg <= '0;
                tv_reg <= 1'b0;
            end
            if (cmd.pos_ld) begin
                cnt_reg <= '0;
                if (cmd.sel_head) begin
                    hx_reg <= pos_x;
                    hy_reg <= pos_y;
                end else begin
                    tx_reg <= pos_x;
                    ty_reg <= pos_y;
                    tv_reg <= 1'b1;
                end
            end
            if (cmd.pix_wr) cnt_reg <= cnt_reg + 1'b1;
            if (cmd.tick_inc) tick_reg <= tick_reg + 1'b1;
            if (cmd.out_ld) ovalid_reg <= 1'b1;
            else if (out_ready) ovalid_reg <= 1'b0;
        end
    end

    assign sts.clr_last = (clr_reg == ADDR_W'(PIX_COUNT - 1));
    assign sts.op       = op_reg;
    assign sts.armed    = armed_reg;
    assign sts.cnt_last = (cnt_reg == 8'hff);
    assign sts.out_free = !ovalid_reg || out_ready;

    assign out_valid = ovalid_reg;
    assign out_pv    = opv_reg;
    assign out_hx    = ohx_reg;
    assign out_hy    = ohy_reg;
    assign out_tx    = otx_reg;
    assign out_ty    = oty_reg;
    assign out_tv    = otv_reg;

endmodule

// ===== hdl/shadebob_heat_stamp_engine.sv =====
// shadebob heat stamp engine
// keeps a 480x360 8-bit heat frame; each tick removes a 16x16 stamp scaled by
// heat_gain at the tail position (once armed) and adds it at the head position
// s_ channel: one word per command; s_tuser[0] = operation (0 tick, 1 read),
//   s_tdata = pixel_x, pixel_y from the lowest bit up
// m_ channel: one word per command; m_tdata = pixel_value, head_x, head_y,
//   tail_x, tail_y; m_tuser[0] = tail_valid
// cfg channel: cfg_index 0 = trail_length, 1 = heat_gain (cfg_data[7:0]);
//   always ready, write only while no command is in flight
// a read goes through the arm, pixel-read and done states; a tick reads and then
//   writes each stamp pixel in turn on the single-port frame store, first for
//   the tail stamp (when armed), then for the head stamp
// one command at a time; the next one is taken as soon as the previous word
//   sits in the output register
// reset: a clearing pass zeroes the frame store, with s_tready low
// when the receiver stalls the output register holds its word and the engine
//   waits at the end of the next command
module shadebob_heat_stamp_engine (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // pixel_x[8:0], pixel_y[17:9]
    input  logic [0:0]  s_tuser,   // operation[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // pixel_value[7:0], head_x[16:8], head_y[25:17],
                                   // tail_x[34:26], tail_y[43:35]
    output logic [0:0]  m_tuser,   // tail_valid[0]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [9:0]  cfg_data
);
    import sbhs_pkg::*;

    cmd_t    cmd;
    status_t sts;
    logic [7:0] pv;
    logic [8:0] hx, hy, tx, ty;
    logic       tv;

    assign cfg_ready = 1'b1;

    sbhs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    sbhs_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .in_op     (s_tuser[0]),
        .in_x      (s_tdata[8:0]),
        .in_y      (s_tdata[17:9]),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_pv    (pv),
        .out_hx    (hx),
        .out_hy    (hy),
        .out_tx    (tx),
        .out_ty    (ty),
        .out_tv    (tv)
    );

    assign m_tdata = {4'd0, ty, tx, hy, hx, pv};
    assign m_tuser = tv;

    // the clearing pass starts right after reset
    a_clear_after_reset: assert property (@(posedge aclk) disable iff (!aresetn)
        !$past(aresetn) |-> !s_tready)
        else $error("input accepted during clearing pass");

    // one command at a time
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second word accepted while busy");

    // a tick word with no tail removal reports a zero tail corner
    a_tail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata[43:26] == 18'd0))
        else $error("tail corner set without tail removal");

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import sbhs_pkg::*;

    localparam logic OP_TICK = 1'b0;
    localparam logic OP_READ = 1'b1;
    localparam int   WAKE_CYCLES = 1100;

    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

    typedef struct packed {
        logic [7:0] pixel;
        logic [8:0] hx;
        logic [8:0] hy;
        logic [8:0] tx;
        logic [8:0] ty;
        logic       tv;
    } heat_word_t;

    typedef struct {
        row_kind_e kind;
        logic      op;      // item: operation; cfg: register index
        int        x;       // item: column; cfg: value
        int        y;
        bit        rel;     // coordinates offset from the held head corner
        bit        typed;   // expected word given below instead of predicted
        logic [7:0] pixel;
    } stim_row_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;
    logic [0:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;
    logic [0:0]  m_tuser;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [9:0]  cfg_data;

    shadebob_heat_stamp_engine dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always begin
        aclk = 1'b1; #10;
        aclk = 1'b0; #10;
    end

    // heat frame predictor state
    logic [7:0]        heat_map [PIX_COUNT];
    logic [8:0]        xpath [512];
    logic [8:0]        ypath [512];
    int                wob [1024];
    logic [9:0]        tick_cnt;
    bit                armed;
    logic [9:0]        trail_len;
    logic [7:0]        gain;
    heat_word_t        held;

    heat_word_t        pending_words [$];
    int                errors;
    int                snd_idle_pct;
    int                rcv_idle_pct;
    bit                hold_req;
    int                hold_left;

    // fixed-point sine, Q60
    function automatic longint unsigned qmul(longint unsigned a, longint unsigned b);
        longint unsigned ah, al, bh, bl;
        ah = a >> 32; al = a & 64'hFFFFFFFF;
        bh = b >> 32; bl = b & 64'hFFFFFFFF;
        return ((ah * bh) << 4) + ((ah * bl + al * bh) >> 28) + ((al * bl) >> 60);
    endfunction

    function automatic longint unsigned qseries(longint unsigned x, bit odd);
        longint unsigned x2, term, sum, den;
        x2 = qmul(x, x);
        term = odd ? x : (64'd1 << 60);
        sum = term;
        for (longint unsigned n = 1; n <= 14; n++) begin
            den = odd ? (2 * n) * (2 * n + 1) : (2 * n - 1) * (2 * n);
            term = qmul(term, x2) / den;
            if (n & 1) sum -= term;
            else sum += term;
        end
        return sum;
    endfunction

    function automatic longint unsigned qsin(longint unsigned num, output bit neg);
        longint unsigned den, q, r, f1, r1, f2, ang, pio2, k, base, m;
        bit dneg;
        den  = 64'd640000000;
        pio2 = 64'h1921FB54442D1847;
        q = num / den; r = num % den;
        f1 = (r << 30) / den; r1 = (r << 30) % den;
        f2 = (r1 << 30) / den;
        ang = (q << 60) + (f1 << 30) + f2;
        k = (ang + (pio2 >> 1)) / pio2;
        base = k * pio2;
        dneg = ang < base;
        m = dneg ? base - ang : ang - base;
        case (k & 3)
            0: begin neg = dneg; return qseries(m, 1'b1); end
            1: begin neg = 1'b0; return qseries(m, 1'b0); end
            2: begin neg = !dneg; return qseries(m, 1'b1); end
            default: begin neg = 1'b1; return qseries(m, 1'b0); end
        endcase
    endfunction

    function automatic longint unsigned qscale(longint unsigned mag, longint unsigned amp,
                                               output bit frac);
        longint unsigned hi, lo, mid;
        hi = amp * (mag >> 30);
        lo = amp * (mag & 64'h3FFFFFFF);
        mid = hi + (lo >> 30);
        frac = ((mid & 64'h3FFFFFFF) != 0) || ((lo & 64'h3FFFFFFF) != 0);
        return mid >> 30;
    endfunction

    function automatic int sine_path(longint unsigned num, longint unsigned amp, int offset);
        bit neg, frac;
        longint unsigned ip;
        ip = qscale(qsin(num, neg), amp, frac);
        if (!neg) return offset + int'(ip);
        return offset - int'(ip) - (frac ? 1 : 0);
    endfunction

    task automatic build_paths();
        bit neg, frac;
        longint unsigned ip, step;
        step = 64'd7853940;
        for (int i = 0; i < 512; i++) begin
            xpath[i] = 9'(sine_path(2 * i * step, 165, 232));
            ypath[i] = 9'(sine_path(i * step, 90, 172));
        end
        for (int i = 0; i < 1024; i++) begin
            ip = qscale(qsin(i * (step / 2), neg), 15, frac);
            wob[i] = neg ? -int'(ip) : int'(ip);
        end
    endtask

    function automatic logic [8:0] corner_x(logic [9:0] t);
        return 9'(int'(xpath[t[8:0]]) + wob[t]);
    endfunction

    function automatic logic [8:0] corner_y(logic [9:0] t);
        return 9'(int'(ypath[t[8:0]]) + wob[t]);
    endfunction

    task automatic apply_stamp(logic [8:0] x0, logic [8:0] y0, bit add);
        int px, py, amt, v;
        for (int r = 0; r < 16; r++) begin
            for (int c = 0; c < 16; c++) begin
                px = x0 + c; py = y0 + r;
                amt = STAMP_ROM[r * 16 + c] * gain;
                if (px < FRAME_WIDTH && py < FRAME_HEIGHT) begin
                    v = heat_map[py * FRAME_WIDTH + px];
                    if (add) v = (v + amt > 255) ? 255 : v + amt;
                    else v = (amt > v) ? 0 : v - amt;
                    heat_map[py * FRAME_WIDTH + px] = 8'(v);
                end
            end
        end
    endtask

    task automatic predict_heat(logic op, logic [8:0] x, logic [8:0] y, output heat_word_t w);
        logic [9:0] t;
        w = '0;
        if (op == OP_TICK) begin
            if (tick_cnt >= trail_len) armed = 1'b1;
            if (armed) begin
                t = tick_cnt - trail_len;
                held.tx = corner_x(t);
                held.ty = corner_y(t);
                held.tv = 1'b1;
                apply_stamp(held.tx, held.ty, 1'b0);
            end else begin
                held.tx = '0; held.ty = '0; held.tv = 1'b0;
            end
            held.hx = corner_x(tick_cnt);
            held.hy = corner_y(tick_cnt);
            apply_stamp(held.hx, held.hy, 1'b1);
            tick_cnt = tick_cnt + 1'b1;
        end else if (x < FRAME_WIDTH && y < FRAME_HEIGHT) begin
            w.pixel = heat_map[y * FRAME_WIDTH + x];
        end
        w.hx = held.hx; w.hy = held.hy;
        w.tx = held.tx; w.ty = held.ty; w.tv = held.tv;
    endtask

    task automatic send_word(logic op, logic [8:0] x, logic [8:0] y, bit typed,
                             logic [7:0] tpix);
        heat_word_t w;
        while ($urandom_range(0, 99) < snd_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {6'd0, y, x};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_heat(op, x, y, w);
        if (typed) w = '{pixel: tpix, default: '0};
        pending_words.push_back(w);
    endtask

    task automatic write_reg(logic idx, logic [9:0] value);
        s_tvalid <= 1'b0;
        wait (pending_words.size() == 0);
        repeat (WAKE_CYCLES) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        if (idx == CFG_TRAIL[0]) trail_len = value;
        else gain = value[7:0];
    endtask

    // result side
    initial begin
        heat_word_t w, got;
        m_tready = 1'b0;
        hold_left = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                got = '{pixel: m_tdata[7:0], hx: m_tdata[16:8], hy: m_tdata[25:17],
                        tx: m_tdata[34:26], ty: m_tdata[43:35], tv: m_tuser[0]};
                if (pending_words.size() == 0) begin
                    $display("%0t: unexpected word %h", $time, got);
                    errors++;
                end else begin
                    w = pending_words.pop_front();
                    if (got !== w) begin
                        $display("%0t: mismatch expected %h actual %h", $time, w, got);
                        errors++;
                    end
                end
            end
            if (hold_req) begin
                hold_req = 1'b0;
                hold_left = 4000;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= rcv_idle_pct);
            end
        end
    end

    initial begin
        #100ms;
        $display("Mismatches found");
        $finish;
    end

    initial begin
        stim_row_t rows [$];
        int trails [6];
        int gains  [6];
        logic [8:0] rx, ry;
        logic op;
        trails = '{3, 1, 0, 1023, 7, 2};
        gains  = '{8, 255, 1, 0, 100, 37};
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        cfg_valid = 1'b0;
        cfg_index = 1'b0;
        cfg_data  = '0;
        errors = 0;
        hold_req = 1'b0;
        snd_idle_pct = 27;
        rcv_idle_pct = 75;
        build_paths();
        foreach (heat_map[i]) heat_map[i] = '0;
        tick_cnt = '0; armed = 1'b0; trail_len = 10'd500; gain = 8'd8; held = '0;

        // empty frame reads, in and out of range
        rows.push_back('{ROW_ITEM, OP_READ, 0, 0, 0, 1, 8'd0});
        rows.push_back('{ROW_ITEM, OP_READ, 479, 359, 0, 1, 8'd0});
        rows.push_back('{ROW_ITEM, OP_READ, 480, 0, 0, 1, 8'd0});
        rows.push_back('{ROW_ITEM, OP_READ, 0, 360, 0, 1, 8'd0});
        rows.push_back('{ROW_ITEM, OP_READ, 511, 511, 0, 1, 8'd0});
        // saturation with full gain
        rows.push_back('{ROW_CFG, CFG_GAIN[0], 255, 0, 0, 0, 8'd0});
        rows.push_back('{ROW_ITEM, OP_TICK, 0, 0, 0, 0, 8'd0});
        rows.push_back('{ROW_ITEM, OP_READ, 7, 7, 1, 0, 8'd0});
        rows.push_back('{ROW_ITEM, OP_READ, 0, 0, 1, 0, 8'd0});
        rows.push_back('{ROW_ITEM, OP_READ, 15, 15, 1, 0, 8'd0});
        // arming and tail removal
        rows.push_back('{ROW_CFG, CFG_TRAIL[0], 1, 0, 0, 0, 8'd0});
        rows.push_back('{ROW_CFG, CFG_GAIN[0], 3, 0, 0, 0, 8'd0});
        rows.push_back('{ROW_ITEM, OP_TICK, 0, 0, 0, 0, 8'd0});
        rows.push_back('{ROW_ITEM, OP_READ, 8, 8, 1, 0, 8'd0});
        rows.push_back('{ROW_ITEM, OP_TICK, 0, 0, 0, 0, 8'd0});
        // zero trail: tail equals head
        rows.push_back('{ROW_CFG, CFG_TRAIL[0], 0, 0, 0, 0, 8'd0});
        rows.push_back('{ROW_ITEM, OP_TICK, 0, 0, 0, 0, 8'd0});
        rows.push_back('{ROW_ITEM, OP_READ, 7, 8, 1, 0, 8'd0});
        rows.push_back('{ROW_CFG, CFG_GAIN[0], 0, 0, 0, 0, 8'd0});
        rows.push_back('{ROW_ITEM, OP_TICK, 0, 0, 0, 0, 8'd0});
        rows.push_back('{ROW_ITEM, OP_READ, 3, 3, 1, 0, 8'd0});
        rows.push_back('{ROW_CFG, CFG_TRAIL[0], 1023, 0, 0, 0, 8'd0});

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (rows[i]) begin
            if (rows[i].kind == ROW_CFG) begin
                write_reg(rows[i].op, 10'(rows[i].x));
            end else begin
                rx = rows[i].rel ? 9'(held.hx + rows[i].x) : 9'(rows[i].x);
                ry = rows[i].rel ? 9'(held.hy + rows[i].y) : 9'(rows[i].y);
                send_word(rows[i].op, rx, ry, rows[i].typed, rows[i].pixel);
            end
        end

        for (int ph = 0; ph < 6; ph++) begin
            write_reg(CFG_TRAIL[0], 10'(trails[ph]));
            write_reg(CFG_GAIN[0], 10'(gains[ph]));
            case (ph / 2)
                0: begin snd_idle_pct = 27; rcv_idle_pct = 75; end
                1: begin snd_idle_pct = 75; rcv_idle_pct = 27; end
                default: begin snd_idle_pct = 0; rcv_idle_pct = 0; end
            endcase
            // long receiver stall while reads keep coming
            if (ph == 1) hold_req = 1'b1;
            for (int n = 0; n < 115; n++) begin
                if (ph == 3 && n == 57) begin
                    s_tvalid <= 1'b0;
                    wait (pending_words.size() == 0);
                end
                op = ($urandom_range(0, 99) < 35) ? OP_TICK : OP_READ;
                if (ph == 1 && n < 20) op = OP_READ;
                if ($urandom_range(0, 99) < 30) begin
                    rx = 9'($urandom_range(0, 511));
                    ry = 9'($urandom_range(0, 511));
                end else if ($urandom_range(0, 1) == 0) begin
                    rx = 9'(held.hx + $urandom_range(0, 17) - 1);
                    ry = 9'(held.hy + $urandom_range(0, 17) - 1);
                end else begin
                    rx = 9'(held.tx + $urandom_range(0, 17) - 1);
                    ry = 9'(held.ty + $urandom_range(0, 17) - 1);
                end
                send_word(op, rx, ry, 1'b0, 8'd0);
            end
        end
        s_tvalid <= 1'b0;

        wait (pending_words.size() == 0);
        repeat (WAKE_CYCLES) @(posedge aclk);
        if (errors == 0 && pending_words.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
